// ----- rtl/dr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dr_pkg
// Shared types and constants for the descramble and redact byte stream core.
// ----------------------------------------------------------------------------
package dr_pkg;

    // Configuration register indexes
    localparam int          CFG_INDEX_W     = 3;
    localparam logic [2:0]  CFG_KEY         = 3'd0;
    localparam logic [2:0]  CFG_IDENT_LOW   = 3'd1;
    localparam logic [2:0]  CFG_IDENT_MID   = 3'd2;
    localparam logic [2:0]  CFG_IDENT_HIGH  = 3'd3;
    localparam logic [2:0]  CFG_IDENT_LEN   = 3'd4;

    // Window geometry
    localparam int          KEY_SPAN        = 6;
    localparam int          MARK_SPAN       = 12;
    localparam int          MARK_TAG_LEN    = 5;
    localparam int          IDENT_REG_BYTES = 20;
    localparam int          IDENT_LEN_W     = 5;

    // "src=P", first character in the lowest byte
    localparam logic [MARK_TAG_LEN*8-1:0] MARK_TAG = 40'h50_3d_63_72_73;

    // Character codes
    localparam logic [7:0]  MASK_CHAR       = 8'h58;    // 'X'
    localparam logic [7:0]  SPACE_CHAR      = 8'h20;
    localparam logic [7:0]  PRINT_LOW       = 8'h20;
    localparam logic [7:0]  PRINT_END       = 8'h7f;

    // Per-cell control handed from a window to each of its cells
    typedef struct packed {
        logic ins;      // take the incoming byte at this position
        logic shift;    // take the neighbor's value (head leaves the window)
        logic mask;     // overwrite with the mask character
    } dr_cell_ctl_t;

endpackage : dr_pkg
`default_nettype wire

// ----- rtl/dr_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dr_cell
// One byte position of a sliding window: insert, compare, mask and shift.
// ----------------------------------------------------------------------------
module dr_cell (
    input  wire logic                 aclk,
    input  wire dr_pkg::dr_cell_ctl_t ctl,
    input  wire logic [7:0]           new_byte,
    input  wire logic [7:0]           pattern,
    input  wire logic [7:0]           next_in,
    output logic      [7:0]           pm,
    output logic                      eq
);
    import dr_pkg::*;

    logic [7:0] w_reg;
    logic [7:0] w_next;
    logic [7:0] cur;

    // Value after insertion, compared and optionally masked
    always_comb begin
        cur    = ctl.ins ? new_byte : w_reg;
        eq     = (cur == pattern);
        pm     = ctl.mask ? MASK_CHAR : cur;
        w_next = ctl.shift ? next_in : pm;
    end

    // Hold the byte
    always_ff @(posedge aclk) begin
        w_reg <= w_next;
    end

endmodule : dr_cell
`default_nettype wire

// ----- rtl/dr_window.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dr_window
// One masking pass: a row of byte cells filled from the head side, an input
// holding register and an output register. A byte leaves the head once the
// window reaches its span; at the end of a message the window is flushed.
// ----------------------------------------------------------------------------
module dr_window #(
    parameter int DEPTH  = 12,
    parameter int FILL_W = $clog2(DEPTH + 1)
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Pass configuration
    input  wire logic [FILL_W-1:0]      span,
    input  wire logic [DEPTH-1:0]       cmp_en,
    input  wire logic [DEPTH-1:0]       mask_en,
    input  wire logic [DEPTH-1:0][7:0]  pattern,
    // Upstream
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             in_byte,
    input  wire logic                   in_last,
    // Downstream
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [7:0]             out_byte,
    output logic                        out_last
);
    import dr_pkg::*;

    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               flush_reg, flush_next;
    logic               pend_v_reg, pend_v_next;
    logic [7:0]         pend_b_reg;
    logic               pend_l_reg;
    logic               out_v_reg, out_v_next;
    logic [7:0]         out_b_reg;
    logic               out_l_reg;

    logic               out_free;
    logic               can_push, push_emit, push_fire;
    logic               drain, drain_fire, flush_fire;
    logic               emit_fire, emit_last, cmp_on, hit;
    logic [FILL_W-1:0]  fill_after;

    dr_cell_ctl_t       ctl [DEPTH];
    logic [7:0]         pm  [DEPTH];
    logic [DEPTH-1:0]   eq;

    // Decide what the window does this cycle
    always_comb begin
        out_free   = !out_v_reg || out_ready;
        can_push   = pend_v_reg && !flush_reg && (fill_reg < span);
        push_emit  = ((fill_reg + FILL_W'(1)) == span);
        push_fire  = can_push && (!push_emit || out_free);
        drain      = pend_v_reg && !flush_reg && (fill_reg >= span);
        drain_fire = drain && out_free;
        flush_fire = flush_reg && out_free;
        emit_fire  = (push_fire && push_emit) || drain_fire || flush_fire;
        cmp_on     = (push_fire && push_emit) || drain_fire;
        hit        = cmp_on && (&(eq | ~cmp_en));
        fill_after = fill_reg + FILL_W'(push_fire) - FILL_W'(emit_fire);
        emit_last  = (push_fire && push_emit && pend_l_reg && (fill_reg == '0))
                   || (flush_fire && (fill_reg == FILL_W'(1)));
        in_ready   = !pend_v_reg || push_fire;
    end

    // Row of cells
    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        localparam logic [FILL_W-1:0] POS = FILL_W'(j);

        always_comb begin
            ctl[j].ins   = push_fire && (fill_reg == POS);
            ctl[j].shift = emit_fire;
            ctl[j].mask  = hit && mask_en[j];
        end

        dr_cell u_cell (
            .aclk     (aclk),
            .ctl      (ctl[j]),
            .new_byte (pend_b_reg),
            .pattern  (pattern[j]),
            .next_in  ((j + 1 < DEPTH) ? pm[(j + 1) % DEPTH] : pm[j]),
            .pm       (pm[j]),
            .eq       (eq[j])
        );
    end

    // Next control state
    always_comb begin
        fill_next  = fill_after;
        flush_next = flush_reg;
        if (flush_fire && (fill_reg == FILL_W'(1))) begin
            flush_next = 1'b0;
        end
        if (push_fire && pend_l_reg && (fill_after != '0)) begin
            flush_next = 1'b1;
        end
        pend_v_next = pend_v_reg;
        if (in_ready) begin
            pend_v_next = in_valid;
        end
        out_v_next = out_v_reg;
        if (emit_fire) begin
            out_v_next = 1'b1;
        end else if (out_ready) begin
            out_v_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            flush_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            flush_reg  <= flush_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload registers: load the holding stage on a transfer, the output on an emit
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pend_b_reg <= in_byte;
            pend_l_reg <= in_last;
        end
        if (emit_fire) begin
            out_b_reg <= pm[0];
            out_l_reg <= emit_last;
        end
    end

    assign out_valid = out_v_reg;
    assign out_byte  = out_b_reg;
    assign out_last  = out_l_reg;

    // The window never holds its full depth at rest
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < FILL_W'(DEPTH))
        else $error("window fill reached its depth");

    // A flush only runs while bytes remain
    a_flush_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> (fill_reg != '0))
        else $error("flush active on an empty window");

    // Emitting the final byte of a message leaves the window empty
    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && emit_last) |=> ((fill_reg == '0) && !flush_reg))
        else $error("window not empty after final byte");

endmodule : dr_window
`default_nettype wire

// ----- rtl/descramble_and_redact_stream_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// descramble_and_redact_stream_core
// Descrambles a response byte stream with a 6-byte key and redacts it in
// three sliding-window passes plus a printable-character filter.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one scrambled byte per transfer, s_in_last on the final byte
//   of a message. m_* channel: one printable byte per transfer in the same
//   order, m_out_last on the final byte. cfg_* channel: register writes
//   (key, identifier bytes, identifier length), taken every cycle; write
//   them only between messages or while the stream is quiet.
//   Within a message throughput is one byte per cycle each way while m_ready
//   stays high. Each pass is a row of cells that moves one byte per cycle;
//   the windows hold up to 11, up to identifier length - 1 and up to 5 bytes,
//   so a byte leaves after those bytes have followed it. After the final byte
//   each pass flushes its window at one byte per cycle while its output is
//   free; the marker pass then takes at most one byte into its holding stage.
//   When m_ready is low the output register holds its byte and the stall
//   reaches s_ready once every stage register is occupied.
//   Reset clears the key position, window fills and registers; window
//   contents need no clearing.
// ----------------------------------------------------------------------------
module descramble_and_redact_stream_core #(
    parameter int IDENT_MAX_LENGTH = 20
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [63:0]                       cfg_data,
    // Input stream
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_in_byte,
    input  wire logic                              s_in_last,
    // Output stream
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [6:0]                        m_out_byte,
    output logic                                   m_out_last
);
    import dr_pkg::*;

    localparam int IDENT_CAP = (IDENT_MAX_LENGTH < IDENT_REG_BYTES) ?
                               IDENT_MAX_LENGTH : IDENT_REG_BYTES;
    localparam int MARK_W    = $clog2(MARK_SPAN + 1);
    localparam int IDENT_W   = $clog2(IDENT_CAP + 1);
    localparam int KEY_W     = $clog2(KEY_SPAN + 1);

    localparam logic [MARK_SPAN-1:0][7:0] MARK_PAT =
        {{((MARK_SPAN - MARK_TAG_LEN) * 8){1'b0}}, MARK_TAG};
    localparam logic [MARK_SPAN-1:0] MARK_CMP  = MARK_SPAN'({MARK_TAG_LEN{1'b1}});
    localparam logic [MARK_SPAN-1:0] MARK_MASK = ~MARK_CMP;
    localparam logic [KEY_SPAN-1:0]  KEY_ALL   = '1;

    // Configuration registers
    logic [KEY_SPAN-1:0][7:0]   key_bytes_reg;
    logic [63:0]                ident_low_reg;
    logic [63:0]                ident_mid_reg;
    logic [31:0]                ident_high_reg;
    logic [IDENT_LEN_W-1:0]     ident_length_reg;

    logic [2:0]                 key_pos_reg, key_pos_next;

    logic [IDENT_REG_BYTES-1:0][7:0] ident_all;
    logic [IDENT_CAP-1:0][7:0]  ident_pat;
    logic [IDENT_CAP-1:0]       ident_cmp;
    logic [IDENT_LEN_W-1:0]     ident_act;
    logic [IDENT_W-1:0]         ident_span;

    logic [7:0]                 plain_byte;
    logic                       mk_valid, mk_ready, mk_last;
    logic [7:0]                 mk_byte;
    logic                       id_valid, id_ready, id_last;
    logic [7:0]                 id_byte;
    logic [7:0]                 ky_byte;

    // Write configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_bytes_reg    <= '0;
            ident_low_reg    <= '0;
            ident_mid_reg    <= '0;
            ident_high_reg   <= '0;
            ident_length_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_KEY:        key_bytes_reg    <= cfg_data[KEY_SPAN*8-1:0];
                CFG_IDENT_LOW:  ident_low_reg    <= cfg_data;
                CFG_IDENT_MID:  ident_mid_reg    <= cfg_data;
                CFG_IDENT_HIGH: ident_high_reg   <= cfg_data[31:0];
                CFG_IDENT_LEN:  ident_length_reg <= cfg_data[IDENT_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Descramble at the input transfer and advance the key position
    always_comb begin
        plain_byte   = s_in_byte ^ key_bytes_reg[key_pos_reg];
        key_pos_next = key_pos_reg;
        if (s_valid && s_ready) begin
            if (s_in_last || (key_pos_reg == 3'(KEY_SPAN - 1))) begin
                key_pos_next = '0;
            end else begin
                key_pos_next = key_pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_pos_reg <= '0;
        end else begin
            key_pos_reg <= key_pos_next;
        end
    end

    // Identifier pass setup; an overlong length disables the pass
    always_comb begin
        ident_all = {ident_high_reg, ident_mid_reg, ident_low_reg};
        ident_pat = ident_all[IDENT_CAP-1:0];
        ident_act = (ident_length_reg <= IDENT_LEN_W'(IDENT_CAP)) ?
                    ident_length_reg : '0;
        for (int i = 0; i < IDENT_CAP; i++) begin
            ident_cmp[i] = (IDENT_LEN_W'(i) < ident_act);
        end
        ident_span = (ident_act == '0) ? IDENT_W'(1) : ident_act[IDENT_W-1:0];
    end

    // Pass one: marker window
    dr_window #(
        .DEPTH  (MARK_SPAN),
        .FILL_W (MARK_W)
    ) u_mark (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .span      (MARK_W'(MARK_SPAN)),
        .cmp_en    (MARK_CMP),
        .mask_en   (MARK_MASK),
        .pattern   (MARK_PAT),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_byte   (plain_byte),
        .in_last   (s_in_last),
        .out_valid (mk_valid),
        .out_ready (mk_ready),
        .out_byte  (mk_byte),
        .out_last  (mk_last)
    );

    // Pass two: identifier window
    dr_window #(
        .DEPTH  (IDENT_CAP),
        .FILL_W (IDENT_W)
    ) u_ident (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .span      (ident_span),
        .cmp_en    (ident_cmp),
        .mask_en   (ident_cmp),
        .pattern   (ident_pat),
        .in_valid  (mk_valid),
        .in_ready  (mk_ready),
        .in_byte   (mk_byte),
        .in_last   (mk_last),
        .out_valid (id_valid),
        .out_ready (id_ready),
        .out_byte  (id_byte),
        .out_last  (id_last)
    );

    // Pass three: key window, its output register drives the result channel
    dr_window #(
        .DEPTH  (KEY_SPAN),
        .FILL_W (KEY_W)
    ) u_key (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .span      (KEY_W'(KEY_SPAN)),
        .cmp_en    (KEY_ALL),
        .mask_en   (KEY_ALL),
        .pattern   (key_bytes_reg),
        .in_valid  (id_valid),
        .in_ready  (id_ready),
        .in_byte   (id_byte),
        .in_last   (id_last),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_byte  (ky_byte),
        .out_last  (m_out_last)
    );

    // Pass four: replace non-printable bytes with a space
    always_comb begin
        if ((ky_byte < PRINT_LOW) || (ky_byte >= PRINT_END)) begin
            m_out_byte = SPACE_CHAR[6:0];
        end else begin
            m_out_byte = ky_byte[6:0];
        end
    end

endmodule : descramble_and_redact_stream_core
`default_nettype wire

// ----- bench/tb_descramble_and_redact_stream_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_descramble_and_redact_stream_core
// Self-checking bench for the descramble and redact stream core. A short
// table of directed messages comes first: byte extremes, the marker mask
// with and without room behind it, key and identifier masking, and identifier
// lengths past and at the limit. Random messages follow under several
// register settings, with some settings changed part way through a message.
// Each output is checked against the table's text or a bit-accurate predictor.
// ----------------------------------------------------------------------------
module tb_descramble_and_redact_stream_core;
    import dr_pkg::*;

    localparam int IDENT_MAX      = 20;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 70;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;   // decodes to no register

    typedef enum logic [1:0] {ROW_CFG, ROW_TEXT, ROW_FILL} row_kind_t;

    // One directed message or one register write
    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [63:0]            reg_val;
        string                  text;
        logic [7:0]             fill_byte;
        int                     fill_count;
        string                  want;       // empty: checked against the predictor
    } stim_row_t;

    typedef struct packed {
        logic [6:0] text;
        logic       last;
    } out_char_t;

    // Clock, reset and block ports
    logic                   aclk       = 1'b0;
    logic                   aresetn    = 1'b0;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [63:0]            cfg_data   = '0;
    logic                   s_valid    = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_in_byte  = '0;
    logic                   s_in_last  = 1'b0;
    logic                   m_valid;
    logic                   m_ready    = 1'b0;
    logic [6:0]             m_out_byte;
    logic                   m_out_last;

    // Predictor registers and windows
    logic [47:0]  key_reg   = '0;
    logic [63:0]  ident_lo  = '0;
    logic [63:0]  ident_mid = '0;
    logic [31:0]  ident_hi  = '0;
    logic [4:0]   ident_len = '0;
    int           key_pos   = 0;
    logic [7:0]   marker_q[$];
    logic [7:0]   ident_q[$];
    logic [7:0]   keyhit_q[$];

    out_char_t    step_chars[$];
    out_char_t    pending_chars[$];
    logic [7:0]   plain_msg[$];

    bit           tx_idle        = 1'b0;
    bit           rx_idle        = 1'b0;
    int           stall_left     = 0;
    int           want_pos       = 0;
    int           errors         = 0;
    int           chars_checked  = 0;
    int           directed_bytes = 0;
    int           random_bytes   = 0;
    int           reg_writes     = 0;
    int           phases         = 0;
    int           quiet_cycles   = 0;

    stim_row_t directed [0:16] = '{
        '{ROW_FILL, CFG_KEY, 64'h0, "", 8'h00, 1, " "},
        '{ROW_FILL, CFG_KEY, 64'h0, "", 8'hff, 1, " "},
        '{ROW_FILL, CFG_KEY, 64'h0, "", 8'h7f, 1, " "},
        '{ROW_TEXT, CFG_KEY, 64'h0, "src=P1234567", 8'h00, 0, "src=PXXXXXXX"},
        '{ROW_TEXT, CFG_KEY, 64'h0, "src=P123456", 8'h00, 0, "src=P123456"},
        '{ROW_CFG, CFG_KEY, 64'hc3c3_5aa5_3cc3_0ff0, "", 8'h00, 0, ""},
        '{ROW_CFG, CFG_SPARE, 64'hffff_ffff_ffff_ffff, "", 8'h00, 0, ""},
        '{ROW_FILL, CFG_KEY, 64'h0, "", 8'h00, 6, "XXXXXX"},
        '{ROW_CFG, CFG_KEY, 64'h0, "", 8'h00, 0, ""},
        '{ROW_CFG, CFG_IDENT_LOW, 64'h6261, "", 8'h00, 0, ""},
        '{ROW_CFG, CFG_IDENT_LEN, 64'd2, "", 8'h00, 0, ""},
        '{ROW_TEXT, CFG_KEY, 64'h0, "~ab ", 8'h00, 0, "~XX "},
        '{ROW_TEXT, CFG_KEY, 64'h0, "xsrc=Pab_secret!", 8'h00, 0, ""},
        '{ROW_CFG, CFG_IDENT_LEN, 64'd21, "", 8'h00, 0, ""},
        '{ROW_TEXT, CFG_KEY, 64'h0, "ab", 8'h00, 0, "ab"},
        '{ROW_CFG, CFG_IDENT_LEN, 64'd20, "", 8'h00, 0, ""},
        '{ROW_TEXT, CFG_KEY, 64'h0, "ab", 8'h00, 0, "ab"}
    };

    descramble_and_redact_stream_core #(
        .IDENT_MAX_LENGTH(IDENT_MAX)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Identifier byte k from the three identifier registers
    function automatic logic [7:0] ident_at(input int k);
        logic [159:0] all_bytes;
        all_bytes = {ident_hi, ident_mid, ident_lo};
        return all_bytes[8*k +: 8];
    endfunction

    // Length in force for identifier masking; zero disables the pass
    function automatic int ident_active_len();
        if (ident_len > IDENT_REG_BYTES || ident_len > IDENT_MAX) return 0;
        return int'(ident_len);
    endfunction

    function automatic logic [7:0] rand_print();
        return 8'($urandom_range(8'h21, 8'h7e));
    endfunction

    function automatic logic [63:0] rand_print64();
        logic [63:0] v;
        for (int i = 0; i < 8; i++) v[8*i +: 8] = rand_print();
        return v;
    endfunction

    // Descramble one byte and run it through the four masking passes
    task automatic redact_byte(input logic [7:0] raw, input logic last);
        logic [7:0] p1[$];
        logic [7:0] p2[$];
        logic [7:0] p3[$];
        logic [7:0] c;
        out_char_t  oc;
        int         len;
        int         span;
        bit         hit;
        step_chars.delete();
        c = raw ^ key_reg[8*key_pos +: 8];
        key_pos = last ? 0 : (key_pos + 1) % KEY_SPAN;

        // Marker pass: mask seven bytes after the tag when the window is full
        marker_q.push_back(c);
        if (marker_q.size() == MARK_SPAN) begin
            hit = 1'b1;
            for (int i = 0; i < MARK_TAG_LEN; i++)
                if (marker_q[i] != MARK_TAG[8*i +: 8]) hit = 1'b0;
            if (hit)
                for (int i = MARK_TAG_LEN; i < MARK_SPAN; i++) marker_q[i] = MASK_CHAR;
            p1.push_back(marker_q.pop_front());
        end
        if (last) while (marker_q.size() != 0) p1.push_back(marker_q.pop_front());

        // Identifier pass: release everything beyond the current span
        len  = ident_active_len();
        span = (len == 0) ? 1 : len;
        foreach (p1[j]) begin
            ident_q.push_back(p1[j]);
            while (ident_q.size() >= span) begin
                if (len != 0) begin
                    hit = 1'b1;
                    for (int i = 0; i < len; i++)
                        if (ident_q[i] != ident_at(i)) hit = 1'b0;
                    if (hit)
                        for (int i = 0; i < len; i++) ident_q[i] = MASK_CHAR;
                end
                p2.push_back(ident_q.pop_front());
            end
        end
        if (last) while (ident_q.size() != 0) p2.push_back(ident_q.pop_front());

        // Key pass
        foreach (p2[j]) begin
            keyhit_q.push_back(p2[j]);
            if (keyhit_q.size() == KEY_SPAN) begin
                hit = 1'b1;
                for (int i = 0; i < KEY_SPAN; i++)
                    if (keyhit_q[i] != key_reg[8*i +: 8]) hit = 1'b0;
                if (hit)
                    for (int i = 0; i < KEY_SPAN; i++) keyhit_q[i] = MASK_CHAR;
                p3.push_back(keyhit_q.pop_front());
            end
        end
        if (last) while (keyhit_q.size() != 0) p3.push_back(keyhit_q.pop_front());

        // Printable filter; the final byte of the list carries the end mark
        foreach (p3[j]) begin
            c = p3[j];
            if (c < PRINT_LOW || c >= PRINT_END) c = SPACE_CHAR;
            oc.text = c[6:0];
            oc.last = last && (j == p3.size() - 1);
            step_chars.push_back(oc);
        end
    endtask

    // Hold one byte on the input channel until its transfer, then predict
    task automatic send_byte(input logic [7:0] raw, input logic last, input string want);
        out_char_t  oc;
        logic [7:0] ch;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= raw;
        s_in_last <= last;
        do @(posedge aclk); while (!s_ready);
        redact_byte(raw, last);
        foreach (step_chars[j]) begin
            oc = step_chars[j];
            if (want.len() != 0) begin
                ch = (want_pos < want.len()) ? want.getc(want_pos) : 8'h00;
                oc.text = ch[6:0];
                want_pos++;
            end
            pending_chars.push_back(oc);
        end
    endtask

    // Write one register; the caller drops cfg_valid after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_KEY:        key_reg   = val[47:0];
            CFG_IDENT_LOW:  ident_lo  = val;
            CFG_IDENT_MID:  ident_mid = val;
            CFG_IDENT_HIGH: ident_hi  = val[31:0];
            CFG_IDENT_LEN:  ident_len = val[4:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Wait for every expected byte, then let the pipeline settle
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Register settings, extremes among them
    task automatic load_profile(input int sel);
        logic [63:0] key_text;
        key_text = rand_print64();
        case (sel % 4)
            0: begin
                write_reg(CFG_KEY, '1);
                write_reg(CFG_IDENT_LOW, '1);
                write_reg(CFG_IDENT_MID, '1);
                write_reg(CFG_IDENT_HIGH, '1);
                write_reg(CFG_IDENT_LEN, '1);
            end
            1: begin
                write_reg(CFG_KEY, {$urandom, $urandom});
                write_reg(CFG_IDENT_LOW, rand_print64());
                write_reg(CFG_IDENT_MID, rand_print64());
                write_reg(CFG_IDENT_HIGH, rand_print64());
                write_reg(CFG_IDENT_LEN, 64'($urandom_range(1, 8)));
            end
            2: begin
                write_reg(CFG_KEY, '0);
                write_reg(CFG_IDENT_LOW, rand_print64());
                write_reg(CFG_IDENT_MID, rand_print64());
                write_reg(CFG_IDENT_HIGH, rand_print64());
                write_reg(CFG_IDENT_LEN, 64'd20);
            end
            default: begin
                write_reg(CFG_KEY, {16'($urandom), key_text[47:0]});
                write_reg(CFG_IDENT_LOW, {$urandom, $urandom});
                write_reg(CFG_IDENT_MID, rand_print64());
                write_reg(CFG_IDENT_HIGH, {$urandom, $urandom});
                write_reg(CFG_IDENT_LEN, {$urandom, $urandom});
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Build one plain message from tags, identifiers, keys and filler
    task automatic make_message();
        int len;
        int n;
        len = ident_active_len();
        if (len == 0) len = 3;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 6)) plain_msg.push_back(rand_print());
                3: for (int i = 0; i < MARK_TAG_LEN; i++) plain_msg.push_back(MARK_TAG[8*i +: 8]);
                4: for (int i = 0; i < len; i++) plain_msg.push_back(ident_at(i));
                5: for (int i = 0; i < KEY_SPAN; i++) plain_msg.push_back(key_reg[8*i +: 8]);
                6: repeat ($urandom_range(1, 4)) plain_msg.push_back(8'($urandom));
                7: begin
                    n = $urandom_range(1, len);
                    for (int i = 0; i < n - 1; i++) plain_msg.push_back(ident_at(i));
                    plain_msg.push_back(rand_print());
                end
                8: begin
                    n = $urandom_range(1, KEY_SPAN - 1);
                    for (int i = 0; i < n; i++) plain_msg.push_back(key_reg[8*i +: 8]);
                end
                default: for (int i = 0; i < 4; i++) plain_msg.push_back(MARK_TAG[8*i +: 8]);
            endcase
        end
    endtask

    // Output stall bursts
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check each output transfer against the oldest expected byte
    always @(posedge aclk) begin : check_output
        out_char_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected output: expected none, actual byte %h last %b",
                         $time, m_out_byte, m_out_last);
                errors++;
            end else begin
                exp_c = pending_chars.pop_front();
                if (m_out_byte !== exp_c.text) begin
                    $display("%0t: out_byte mismatch: expected %h actual %h",
                             $time, exp_c.text, m_out_byte);
                    errors++;
                end
                if (m_out_last !== exp_c.last) begin
                    $display("%0t: out_last mismatch: expected %b actual %b",
                             $time, exp_c.last, m_out_last);
                    errors++;
                end
                chars_checked++;
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (directed[r]) begin
            want_pos = 0;
            case (directed[r].kind)
                ROW_CFG: begin
                    drain_and_settle();
                    write_reg(directed[r].reg_idx, directed[r].reg_val);
                    cfg_valid <= 1'b0;
                end
                ROW_TEXT: begin
                    for (int i = 0; i < directed[r].text.len(); i++) begin
                        send_byte(directed[r].text.getc(i), i == directed[r].text.len() - 1,
                                  directed[r].want);
                        directed_bytes++;
                    end
                end
                default: begin
                    for (int i = 0; i < directed[r].fill_count; i++) begin
                        send_byte(directed[r].fill_byte, i == directed[r].fill_count - 1,
                                  directed[r].want);
                        directed_bytes++;
                    end
                end
            endcase
        end

        // Random phases; a phase may end, and the settings change, mid-message
        while (random_bytes < RANDOM_BYTES || plain_msg.size() != 0) begin
            drain_and_settle();
            load_profile(phases);
            if (random_bytes >= RANDOM_BYTES * 3 / 4) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else begin
                tx_idle = $urandom_range(0, 2) != 0;
                rx_idle = $urandom_range(0, 2) != 0;
            end
            for (int k = $urandom_range(8, 40);
                 k > 0 && (random_bytes < RANDOM_BYTES || plain_msg.size() != 0); k--) begin
                if (plain_msg.size() == 0) make_message();
                send_byte(plain_msg[0] ^ key_reg[8*key_pos +: 8], plain_msg.size() == 1, "");
                void'(plain_msg.pop_front());
                random_bytes++;
            end
            phases++;
        end

        drain_and_settle();
        $display("Covered %0d directed and %0d random input bytes over %0d settings phases",
                 directed_bytes, random_bytes, phases);
        $display("Checked %0d output bytes after %0d register writes",
                 chars_checked, reg_writes);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
